FILE: src/tcw_pkg.sv
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W      = $clog2(CELLS);
  localparam int POS_W       = ADDR_W + 1;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int COLOR_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int OP_W        = 4;

  localparam logic [7:0] GLYPH_BLOCK  = 8'd219;
  localparam logic [7:0] GLYPH_SPACE  = 8'd32;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd1;

  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;
  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd1;
  localparam logic [OP_W-1:0] OP_PUT    = 4'd2;
  localparam logic [OP_W-1:0] OP_COPY   = 4'd3;
  localparam logic [OP_W-1:0] OP_DRAIN  = 4'd4;
  localparam logic [OP_W-1:0] OP_FILL   = 4'd5;
  localparam logic [OP_W-1:0] OP_READ   = 4'd6;
  localparam logic [OP_W-1:0] OP_MODIFY = 4'd7;
  localparam logic [OP_W-1:0] OP_RESULT = 4'd8;

  typedef logic [OP_W-1:0] op_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       char_code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] line;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_index;
    logic [15:0]       cell_value;
    logic              scrolled;
  } out_item_t;

  typedef struct packed {
    logic latch;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic       ptr_last;
    logic       wrap;
    logic       on_screen;
    logic [1:0] mode;
  } dp_status_t;

endpackage

FILE: src/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  in_item_t               in_item,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output out_item_t              out_item
);

  logic [15:0]        mem [CELLS];
  logic [15:0]        rdata;

  logic [COLOR_W-1:0] background;
  logic [COLOR_W-1:0] foreground;
  in_item_t           item;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [ADDR_W-1:0]  cursor;
  logic [ADDR_W-1:0]  ptr;
  logic               copy_pend;
  logic [ADDR_W-1:0]  copy_waddr;
  logic               scrolled;
  out_item_t          out_q;

  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  logic               is_nl;
  logic               is_cr;
  logic               last_col;
  logic               last_row;
  logic               wrap;
  logic               on_screen;
  logic [POS_W-1:0]   pos;
  logic [ADDR_W-1:0]  pos_addr;
  logic [7:0]         theme;
  logic [7:0]         glyph;
  logic [15:0]        mod_value;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [15:0]        wdata;
  logic               re;
  logic [ADDR_W-1:0]  raddr;

  assign theme    = {background, foreground};
  assign is_nl    = item.char_code == CODE_NEWLINE;
  assign is_cr    = item.char_code == CODE_RETURN;
  assign last_col = cur_col == COL_W'(COLUMNS - 1);
  assign last_row = cur_row == ROW_W'(ROWS - 1);
  assign wrap     = !is_cr && (is_nl ? last_row : (last_col && last_row));

  assign on_screen = (item.col < COL_W'(COLUMNS)) && (item.line < ROW_W'(ROWS));
  assign pos       = POS_W'(item.line) * POS_W'(COLUMNS) + POS_W'(item.col);
  assign pos_addr  = on_screen ? pos[ADDR_W-1:0] : '0;

  // cursor after a put char item
  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    if (!is_cr) begin
      if (wrap) begin
        row_next = ROW_W'(ROWS - 1);
        col_next = '0;
      end else if (is_nl || last_col) begin
        row_next = cur_row + 1'b1;
        col_next = '0;
      end else begin
        col_next = cur_col + 1'b1;
      end
    end
  end

  // block cursor recolor
  always_comb begin
    glyph = rdata[7:0];
    if (item.mode == MODE_DRAW) begin
      if (glyph inside {GLYPH_SPACE, 8'd0}) begin
        glyph = GLYPH_BLOCK;
      end
      mod_value = {foreground, background, glyph};
    end else begin
      if (glyph == GLYPH_BLOCK) begin
        glyph = GLYPH_SPACE;
      end
      mod_value = {theme, glyph};
    end
  end

  // single write port, the pending copy write has the port to itself
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    if (copy_pend) begin
      we    = 1'b1;
      waddr = copy_waddr;
      wdata = rdata;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          we = 1'b1;
        end
        OP_PUT: begin
          we    = !is_nl && !is_cr;
          waddr = cursor;
          wdata = {theme, item.char_code};
        end
        OP_FILL: begin
          we    = 1'b1;
          wdata = {theme, GLYPH_SPACE};
        end
        OP_MODIFY: begin
          we    = 1'b1;
          waddr = pos_addr;
          wdata = mod_value;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  assign re    = (cmd.op == OP_COPY) || (cmd.op == OP_READ);
  assign raddr = (cmd.op == OP_READ) ? pos_addr : ptr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      background <= BACKGROUND_RESET;
      foreground <= FOREGROUND_RESET;
      cur_row    <= '0;
      cur_col    <= '0;
      cursor     <= '0;
      ptr        <= '0;
      copy_pend  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_BACKGROUND) begin
        background <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_FOREGROUND) begin
        foreground <= cfg_data;
      end
      copy_pend <= cmd.op == OP_COPY;
      case (cmd.op)
        OP_CLEAR, OP_COPY, OP_FILL: begin
          ptr <= ptr + 1'b1;
        end
        OP_PUT: begin
          cur_row <= row_next;
          cur_col <= col_next;
          cursor  <= ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);
          ptr     <= ADDR_W'(2 * COLUMNS);
        end
        OP_DRAIN: begin
          ptr <= ADDR_W'((ROWS - 1) * COLUMNS);
        end
        default: begin
          ptr <= ptr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item     <= in_item;
      scrolled <= 1'b0;
    end else if (cmd.op == OP_PUT) begin
      scrolled <= wrap;
    end
    if (cmd.op == OP_COPY) begin
      copy_waddr <= ptr - ADDR_W'(COLUMNS);
    end
    if (cmd.op == OP_RESULT) begin
      out_q.cursor_index <= cursor;
      out_q.cell_value   <= on_screen ? rdata : 16'd0;
      out_q.scrolled     <= scrolled;
    end
  end

  assign out_item         = out_q;
  assign status.ptr_last  = ptr == ADDR_W'(CELLS - 1);
  assign status.wrap      = wrap;
  assign status.on_screen = on_screen;
  assign status.mode      = item.mode;

endmodule

FILE: src/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_COPY   = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_FILL   = 4'd5;
  localparam logic [3:0] S_READ   = 4'd6;
  localparam logic [3:0] S_MODIFY = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.latch  = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.ptr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.mode == MODE_PUT) begin
          cmd.op     = OP_PUT;
          state_next = status.wrap ? S_COPY : S_READ;
        end else begin
          // read the addressed cell; recolor it for the cursor modes when it is on screen
          cmd.op = OP_READ;
          if ((status.mode inside {MODE_DRAW, MODE_CLEAR}) && status.on_screen) begin
            state_next = S_MODIFY;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_COPY: begin
        cmd.op = OP_COPY;
        if (status.ptr_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.op     = OP_DRAIN;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (status.ptr_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.op     = OP_READ;
        state_next = S_RESULT;
      end
      S_MODIFY: begin
        cmd.op     = OP_MODIFY;
        state_next = S_READ;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted item did not start execution");

  a_modify_only_cursor_modes: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY) |->
      ((status.mode == MODE_DRAW || status.mode == MODE_CLEAR) && status.on_screen))
    else $error("cell modified outside a cursor draw or clear");

  a_result_waits_for_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && out_valid && !out_ready) |=> state == S_RESULT)
    else $error("result register overwritten while still held");

  a_fill_then_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && status.ptr_last) |=> state == S_READ)
    else $error("scroll fill did not end in a cell read");

endmodule

FILE: src/text_console_writer_core.sv
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     in_item   (mode, char_code, col, line)
// out      output     out_valid / out_ready   out_item  (cursor_index, cell_value, scrolled)
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data (4-bit color)
//
// after reset a clearing pass writes zero to all 2000 cells, with in_ready low
// registered memory reads set the timing; one item at a time; put char, newline and carriage
// return: put, read, result; read cell: read, result; draw or clear: read, modify, read, result
// (off screen: read, result); a scroll adds 1840 copies at one cell per cycle, a drain, 80 fills
// the next item is accepted while a result waits on out, then holds until out is free
// cfg_ready is always high; the user writes colors only while no item is in flight (unchecked)
module text_console_writer_core import tcw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
